// ----- rtl/core/udt_pkg.sv -----
// Package for the umlaut digraph transliterator.
// Holds character codes, umlaut codes, the result entry type and the pair decision.
// No dependencies.
package udt_pkg;

  localparam logic [7:0] ChLa = 8'h61;
  localparam logic [7:0] ChLe = 8'h65;
  localparam logic [7:0] ChLo = 8'h6f;
  localparam logic [7:0] ChLu = 8'h75;
  localparam logic [7:0] ChUa = 8'h41;
  localparam logic [7:0] ChUe = 8'h45;
  localparam logic [7:0] ChUo = 8'h4f;
  localparam logic [7:0] ChUu = 8'h55;

  localparam logic [7:0] UmlLa = 8'he4;
  localparam logic [7:0] UmlLo = 8'hf6;
  localparam logic [7:0] UmlLu = 8'hfc;
  localparam logic [7:0] UmlUa = 8'hc4;
  localparam logic [7:0] UmlUo = 8'hd6;
  localparam logic [7:0] UmlUu = 8'hdc;
  localparam logic [7:0] NoCode = 8'h00;

  localparam logic [15:0] CountMax = 16'hffff;

  localparam int OutDepth = 4;
  localparam int OutPtrW = $clog2(OutDepth);
  localparam int OutCntW = $clog2(OutDepth + 1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_out;
    logic [15:0] replaced_total;
  } result_t;

  function automatic logic [7:0] pair_code(input logic [7:0] prev, input logic [7:0] first,
                                           input logic [7:0] second);
    logic lower_block;
    logic upper_block;
    logic [7:0] code;
    lower_block = prev inside {ChLa, ChLe, ChUa, ChUe};
    upper_block = prev inside {ChUa, ChUe};
    code = NoCode;
    if (second == ChLe) begin
      case (first)
        ChLa: code = UmlLa;
        ChLo: code = UmlLo;
        ChLu: code = lower_block ? NoCode : UmlLu;
        ChUa: code = UmlUa;
        ChUo: code = UmlUo;
        ChUu: code = UmlUu;
        default: code = NoCode;
      endcase
    end else if (second == ChUe) begin
      case (first)
        ChUa: code = UmlUa;
        ChUo: code = UmlUo;
        ChUu: code = upper_block ? NoCode : UmlUu;
        default: code = NoCode;
      endcase
    end
    return code;
  endfunction

endpackage

// ----- rtl/core/udt_in_if.sv -----
// Input channel of the umlaut digraph transliterator: valid/ready plus text byte.
// No dependencies.
interface udt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- rtl/core/udt_out_if.sv -----
// Result channel of the umlaut digraph transliterator: valid/ready plus result byte.
// No dependencies.
interface udt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_out;
  logic [15:0] replaced_total;

  modport source (output valid, output out_byte, output last_out, output replaced_total,
                  input ready);
  modport sink (input valid, input out_byte, input last_out, input replaced_total,
                output ready);
endinterface

// ----- rtl/core/umlaut_digraph_transliterator.sv -----
// Top level of the umlaut digraph transliterator.
// Depends on udt_pkg, udt_in_if and udt_out_if.
//
// Usage:
//   in_ch carries one text byte per transaction; end_of_text marks the final byte.
//   out_ch carries result bytes: passed bytes or Latin-1 umlaut codes, last_out on
//   the final byte of a text and the saturating replacement count of the text.
//   One byte is held as lookahead, so a byte leaves only once its successor (or the
//   end of text) has arrived. Each input transaction yields zero, one or two results,
//   written into a four-entry result queue in the cycle of acceptance; out_ch offers
//   the oldest queued result, in order of production.
//   Throughput: one input transaction per cycle while in_ch.ready is high, which it is
//   while the queue has room for two results; since a text adds at most one result per
//   byte on average, a receiver that takes one result per cycle never stalls the input.
//   When the receiver stalls, results stay queued and the input stops once the queue
//   cannot take two more.
//   Reset (rst_n low, synchronous) empties the queue and clears the held byte, the
//   lookbehind byte and the count. End of text clears them too for the next text.
module umlaut_digraph_transliterator (
  input  logic clk,
  input  logic rst_n,
  udt_in_if.sink    in_ch,
  udt_out_if.source out_ch
);

  localparam int PtrW = udt_pkg::OutPtrW;
  localparam int CntW = udt_pkg::OutCntW;

  logic [7:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [7:0]  before_r, before_nxt;
  logic [15:0] count_r, count_nxt;

  udt_pkg::result_t q_r [udt_pkg::OutDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] fill_r;

  logic            acc;
  logic            pop;
  logic [7:0]      code;
  logic            hit;
  logic [15:0]     count_inc;
  logic [1:0]      push_n;
  udt_pkg::result_t res0, res1;
  logic [7:0]      b;
  logic            eot;

  assign b   = in_ch.in_byte;
  assign eot = in_ch.end_of_text;

  assign in_ch.ready = (fill_r <= CntW'(udt_pkg::OutDepth - 2));
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (fill_r != '0);
  assign pop = out_ch.valid && out_ch.ready;

  assign code = udt_pkg::pair_code(before_r, held_r, b);
  assign hit = held_v_r && (code != udt_pkg::NoCode);
  assign count_inc = (count_r == udt_pkg::CountMax) ? count_r : count_r + 16'd1;

  always_comb begin
    res0 = '{out_byte: b, last_out: eot, replaced_total: count_r};
    res1 = '{out_byte: b, last_out: 1'b1, replaced_total: count_r};
    push_n = 2'd0;
    held_nxt = held_r;
    held_v_nxt = held_v_r;
    before_nxt = before_r;
    count_nxt = count_r;
    if (acc) begin
      if (hit) begin
        res0 = '{out_byte: code, last_out: eot, replaced_total: count_inc};
        push_n = 2'd1;
        held_nxt = 8'd0;
        held_v_nxt = 1'b0;
        before_nxt = b;
        count_nxt = count_inc;
      end else if (held_v_r) begin
        res0 = '{out_byte: held_r, last_out: 1'b0, replaced_total: count_r};
        push_n = eot ? 2'd2 : 2'd1;
        before_nxt = held_r;
        held_nxt = b;
      end else begin
        push_n = eot ? 2'd1 : 2'd0;
        held_nxt = b;
        held_v_nxt = 1'b1;
      end
      if (eot) begin
        held_nxt = 8'd0;
        held_v_nxt = 1'b0;
        before_nxt = 8'd0;
        count_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 8'd0;
      held_v_r <= 1'b0;
      before_r <= 8'd0;
      count_r  <= 16'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      before_r <= before_nxt;
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_r + PtrW'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      fill_r <= fill_r + CntW'(push_n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + PtrW'(1)] <= res1;
    end
  end

  assign out_ch.out_byte       = q_r[rd_ptr_r].out_byte;
  assign out_ch.last_out       = q_r[rd_ptr_r].last_out;
  assign out_ch.replaced_total = q_r[rd_ptr_r].replaced_total;

endmodule
